// ----- hdl/upg_pkg.sv -----
package upg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 22;
    localparam int FACTOR_W   = 4;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int FLIM_W     = 5;
    localparam int WLIM_W     = 14;
    localparam int MAX_HEIGHT = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FACTOR_H  = 2'd0,
        REG_FACTOR_W  = 2'd1,
        REG_IN_WIDTH  = 2'd2,
        REG_IN_HEIGHT = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic first;
        logic emit;
        logic plane_end;
    } t_pos_info;

endpackage

// ----- hdl/upg_sum_ram.sv -----
module upg_sum_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 22
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/upg_pos_ctr.sv -----
module upg_pos_ctr #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 8,
    parameter int AW         = 10,
    parameter int FW         = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [upg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [upg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_advance,
    output logic [AW-1:0]                   o_addr,
    output upg_pkg::t_pos_info              o_info
);

    logic [upg_pkg::FACTOR_W-1:0] r_factor_h;
    logic [upg_pkg::FACTOR_W-1:0] r_factor_w;
    logic [upg_pkg::WIDTH_W-1:0]  r_in_width;
    logic [upg_pkg::HEIGHT_W-1:0] r_in_height;

    logic [FW-1:0]              r_sub_col;
    logic [AW-1:0]              r_block_col;
    logic [FW-1:0]              r_sub_row;
    logic [upg_pkg::ROW_W-1:0]  r_block_row;

    logic [upg_pkg::FLIM_W-1:0]   fh;
    logic [upg_pkg::FLIM_W-1:0]   fw;
    logic [upg_pkg::WLIM_W-1:0]   w;
    logic [upg_pkg::HEIGHT_W-1:0] h;
    logic last_sc, last_bc, last_sr, last_br;

    always_comb begin
        if (r_factor_h == '0) begin
            fh = upg_pkg::FLIM_W'(1);
        end else if (upg_pkg::FLIM_W'(r_factor_h) > upg_pkg::FLIM_W'(MAX_FACTOR)) begin
            fh = upg_pkg::FLIM_W'(MAX_FACTOR);
        end else begin
            fh = upg_pkg::FLIM_W'(r_factor_h);
        end
        if (r_factor_w == '0) begin
            fw = upg_pkg::FLIM_W'(1);
        end else if (upg_pkg::FLIM_W'(r_factor_w) > upg_pkg::FLIM_W'(MAX_FACTOR)) begin
            fw = upg_pkg::FLIM_W'(MAX_FACTOR);
        end else begin
            fw = upg_pkg::FLIM_W'(r_factor_w);
        end
        if (r_in_width == '0) begin
            w = upg_pkg::WLIM_W'(1);
        end else if (upg_pkg::WLIM_W'(r_in_width) > upg_pkg::WLIM_W'(MAX_WIDTH)) begin
            w = upg_pkg::WLIM_W'(MAX_WIDTH);
        end else begin
            w = upg_pkg::WLIM_W'(r_in_width);
        end
        if (r_in_height == '0) begin
            h = upg_pkg::HEIGHT_W'(1);
        end else if (r_in_height > upg_pkg::HEIGHT_W'(upg_pkg::MAX_HEIGHT)) begin
            h = upg_pkg::HEIGHT_W'(upg_pkg::MAX_HEIGHT);
        end else begin
            h = r_in_height;
        end
        last_sc = (upg_pkg::FLIM_W'(r_sub_col) + upg_pkg::FLIM_W'(1)) >= fw;
        last_sr = (upg_pkg::FLIM_W'(r_sub_row) + upg_pkg::FLIM_W'(1)) >= fh;
        last_bc = (upg_pkg::WLIM_W'(r_block_col) + upg_pkg::WLIM_W'(1)) >= w;
        last_br = (upg_pkg::HEIGHT_W'(r_block_row) + upg_pkg::HEIGHT_W'(1)) >= h;
    end

    assign o_addr           = r_block_col;
    assign o_info.first     = (r_sub_col == '0) && (r_sub_row == '0);
    assign o_info.emit      = last_sc && last_sr;
    assign o_info.plane_end = last_sc && last_sr && last_bc && last_br;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor_h  <= upg_pkg::FACTOR_W'(2);
            r_factor_w  <= upg_pkg::FACTOR_W'(2);
            r_in_width  <= upg_pkg::WIDTH_W'(1024);
            r_in_height <= upg_pkg::HEIGHT_W'(1024);
            r_sub_col   <= '0;
            r_block_col <= '0;
            r_sub_row   <= '0;
            r_block_row <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (upg_pkg::t_cfg_reg'(i_cfg_idx))
                    upg_pkg::REG_FACTOR_H:  r_factor_h  <= i_cfg_data[upg_pkg::FACTOR_W-1:0];
                    upg_pkg::REG_FACTOR_W:  r_factor_w  <= i_cfg_data[upg_pkg::FACTOR_W-1:0];
                    upg_pkg::REG_IN_WIDTH:  r_in_width  <= i_cfg_data[upg_pkg::WIDTH_W-1:0];
                    upg_pkg::REG_IN_HEIGHT: r_in_height <= i_cfg_data[upg_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (i_advance) begin
                if (!last_sc) begin
                    r_sub_col <= r_sub_col + FW'(1);
                end else begin
                    r_sub_col <= '0;
                    if (!last_bc) begin
                        r_block_col <= r_block_col + AW'(1);
                    end else begin
                        r_block_col <= '0;
                        if (!last_sr) begin
                            r_sub_row <= r_sub_row + FW'(1);
                        end else begin
                            r_sub_row <= '0;
                            if (!last_br) begin
                                r_block_row <= r_block_row + upg_pkg::ROW_W'(1);
                            end else begin
                                r_block_row <= '0;
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- hdl/upsample2d_grad_block_sum_unit.sv -----
// last sample of a block -> accumulate stage register -> output register -> o_valid
// one sample per cycle unless o_stall, one line-memory read and one write per sample
// back-to-back samples of one block are forwarded past the registered memory read
// reset (synchronous, active low) clears the position counters and the pipeline valids
// and restores factors 2 x 2 and a 1024 x 1024 grid; the line memory is not cleared
module upsample2d_grad_block_sum_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [upg_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [upg_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [upg_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [upg_pkg::SUM_W-1:0]       o_block_sum,
    output logic                                   o_plane_done
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int FW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

    logic [AW-1:0]       pos_addr;
    upg_pkg::t_pos_info  pos_info;
    logic                accept;

    logic                         r_s1_valid;
    logic [AW-1:0]                r_s1_addr;
    upg_pkg::t_pos_info           r_s1_info;
    logic [upg_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic                         r_fwd;
    logic [upg_pkg::SUM_W-1:0]    r_fwd_sum;
    logic [upg_pkg::SUM_W-1:0]    mem_rdata;
    logic [upg_pkg::SUM_W-1:0]    base;
    logic [upg_pkg::SUM_W-1:0]    s1_sum;
    logic                         s1_move;

    logic                         r_out_valid;
    logic [upg_pkg::SUM_W-1:0]    r_out_sum;
    logic                         r_out_plane;

    upg_pos_ctr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR),
        .AW         (AW),
        .FW         (FW)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_advance  (accept),
        .o_addr     (pos_addr),
        .o_info     (pos_info)
    );

    upg_sum_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (upg_pkg::SUM_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_addr),
        .i_wdata (s1_sum),
        .i_re    (accept),
        .i_raddr (pos_addr),
        .o_rdata (mem_rdata)
    );

    // accumulate stage
    assign s1_move = r_s1_valid && (!r_s1_info.emit || !r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_move;
    assign accept  = i_valid && !o_stall;

    assign base   = r_fwd ? r_fwd_sum : mem_rdata;
    assign s1_sum = r_s1_info.first ? upg_pkg::SUM_W'(signed'(r_s1_sample))
                                    : base + upg_pkg::SUM_W'(signed'(r_s1_sample));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_move && (r_s1_addr == pos_addr);
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move && r_s1_info.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr   <= pos_addr;
            r_s1_info   <= pos_info;
            r_s1_sample <= i_sample;
            r_fwd_sum   <= s1_sum;
        end
        if (s1_move && r_s1_info.emit) begin
            r_out_sum   <= s1_sum;
            r_out_plane <= r_s1_info.plane_end;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_block_sum  = signed'(r_out_sum);
    assign o_plane_done = r_out_plane;

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> r_s1_valid)
        else $error("accumulate stage lost a word");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_info.emit && r_out_valid && i_stall) |-> o_stall)
        else $error("input not held while result is blocked");

    a_fwd_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_s1_valid && (r_s1_addr == pos_addr)) |=> r_fwd)
        else $error("missing forward on same-entry access");

endmodule

// ----- sim/upsample2d_grad_block_sum_checker.sv -----
`timescale 1ns / 1ps
module upsample2d_grad_block_sum_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [upg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [upg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [upg_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [upg_pkg::SUM_W-1:0]    i_block_sum,
    input  logic                                i_plane_done,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef struct {
        logic signed [upg_pkg::SUM_W-1:0] value;
        logic                             last;
    } t_block_result;

    t_block_result                    expected_sums[$];
    logic signed [upg_pkg::SUM_W-1:0] line_sums [MAX_WIDTH];
    logic [upg_pkg::FACTOR_W-1:0]     factor_h;
    logic [upg_pkg::FACTOR_W-1:0]     factor_w;
    logic [upg_pkg::WIDTH_W-1:0]      in_width;
    logic [upg_pkg::HEIGHT_W-1:0]     in_height;
    int unsigned                      sub_col;
    int unsigned                      block_col;
    int unsigned                      sub_row;
    int unsigned                      block_row;
    int                               errors = 0;

    function automatic int unsigned limit_to(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic add_sample(input logic signed [upg_pkg::SAMPLE_W-1:0] s);
        int unsigned                      fh, fw, w, h, col;
        logic                             last_sc, last_bc, last_sr, last_br;
        logic signed [upg_pkg::SUM_W-1:0] acc;
        fh = limit_to(factor_h, MAX_FACTOR);
        fw = limit_to(factor_w, MAX_FACTOR);
        w = limit_to(in_width, MAX_WIDTH);
        h = limit_to(in_height, upg_pkg::MAX_HEIGHT);
        last_sc = sub_col + 1 >= fw;
        last_bc = block_col + 1 >= w;
        last_sr = sub_row + 1 >= fh;
        last_br = block_row + 1 >= h;
        col = (block_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : block_col;
        if (sub_col == 0 && sub_row == 0) begin
            acc = upg_pkg::SUM_W'(s);
        end else begin
            acc = line_sums[col] + upg_pkg::SUM_W'(s);
        end
        line_sums[col] = acc;
        if (last_sc && last_sr) begin
            expected_sums.push_back('{acc, last_bc && last_br});
        end
        if (!last_sc) begin
            sub_col++;
        end else begin
            sub_col = 0;
            if (!last_bc) begin
                block_col++;
            end else begin
                block_col = 0;
                if (!last_sr) begin
                    sub_row++;
                end else begin
                    sub_row = 0;
                    block_row = last_br ? 0 : block_row + 1;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_block_result head;
        if (!i_rst_n) begin
            factor_h = 2;
            factor_w = 2;
            in_width = 1024;
            in_height = 1024;
            sub_col = 0;
            block_col = 0;
            sub_row = 0;
            block_row = 0;
            expected_sums.delete();
        end else begin
            if (i_cfg_we) begin
                unique case (upg_pkg::t_cfg_reg'(i_cfg_idx))
                    upg_pkg::REG_FACTOR_H:  factor_h = i_cfg_data[upg_pkg::FACTOR_W-1:0];
                    upg_pkg::REG_FACTOR_W:  factor_w = i_cfg_data[upg_pkg::FACTOR_W-1:0];
                    upg_pkg::REG_IN_WIDTH:  in_width = i_cfg_data[upg_pkg::WIDTH_W-1:0];
                    upg_pkg::REG_IN_HEIGHT: in_height = i_cfg_data[upg_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                add_sample(i_sample);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_sums.size() == 0) begin
                    errors++;
                    $error("block_sum: expected no word, got %0d", i_block_sum);
                end else begin
                    head = expected_sums.pop_front();
                    if (i_block_sum !== head.value) begin
                        errors++;
                        $error("block_sum: expected %0d, got %0d", head.value, i_block_sum);
                    end
                    if (i_plane_done !== head.last) begin
                        errors++;
                        $error("plane_done: expected %0d, got %0d", head.last, i_plane_done);
                    end
                end
            end
        end
        o_fail_count <= errors;
        o_pending <= expected_sums.size();
    end

endmodule

// ----- sim/upsample2d_grad_block_sum_unit_tb.sv -----
`timescale 1ns / 1ps
module upsample2d_grad_block_sum_unit_tb;

    localparam int LINE_MAX   = 1024;
    localparam int FACTOR_MAX = 8;

    typedef enum {FILL_MIX, FILL_MIN, FILL_MAX} t_fill;

    localparam logic signed [upg_pkg::SAMPLE_W-1:0] SAMPLE_LO =
        {1'b1, {(upg_pkg::SAMPLE_W-1){1'b0}}};
    localparam logic signed [upg_pkg::SAMPLE_W-1:0] SAMPLE_HI =
        {1'b0, {(upg_pkg::SAMPLE_W-1){1'b1}}};

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    upg_pkg::t_cfg_reg                   cfg_idx = upg_pkg::REG_FACTOR_H;
    logic [upg_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic signed [upg_pkg::SAMPLE_W-1:0] sample = '0;
    logic                                out_stall = 1'b0;
    logic                                in_stall;
    logic                                out_valid;
    logic signed [upg_pkg::SUM_W-1:0]    block_sum;
    logic                                plane_done;
    int                                  fail_count;
    int                                  pending;
    int                                  stall_left = 0;
    bit                                  out_quiet = 1'b0;
    bit                                  in_quiet = 1'b0;

    always #4 clk = ~clk;

    upsample2d_grad_block_sum_unit #(
        .MAX_WIDTH (LINE_MAX),
        .MAX_FACTOR(FACTOR_MAX)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_sample    (sample),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_block_sum (block_sum),
        .o_plane_done(plane_done)
    );

    upsample2d_grad_block_sum_checker #(
        .MAX_WIDTH (LINE_MAX),
        .MAX_FACTOR(FACTOR_MAX)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_sample    (sample),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_block_sum (block_sum),
        .i_plane_done(plane_done),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        if ($urandom_range(0, 199) == 0) begin
            out_quiet <= !out_quiet;
        end
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!out_quiet && $urandom_range(0, 99) < 25) begin
            out_stall <= 1'b1;
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(5, 20)
                                                       : $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic int unsigned clip(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 149) == 0) in_quiet = !in_quiet;
        if (in_quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    function automatic logic signed [upg_pkg::SAMPLE_W-1:0] pick_sample(input t_fill f);
        int r;
        case (f)
            FILL_MIN: return SAMPLE_LO;
            FILL_MAX: return SAMPLE_HI;
            default: begin
                r = $urandom_range(0, 99);
                if (r < 70) return upg_pkg::SAMPLE_W'($urandom);
                if (r < 80) return SAMPLE_LO;
                if (r < 90) return SAMPLE_HI;
                return upg_pkg::SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
            end
        endcase
    endfunction

    function automatic logic [upg_pkg::CFG_DATA_W-1:0] pick_factor();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return upg_pkg::CFG_DATA_W'($urandom_range(9, 15));
        if (r < 4) return upg_pkg::CFG_DATA_W'($urandom_range(5, 8));
        return upg_pkg::CFG_DATA_W'($urandom_range(1, 4));
    endfunction

    function automatic logic [upg_pkg::CFG_DATA_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r < 3) return upg_pkg::CFG_DATA_W'($urandom_range(5, 12));
        return upg_pkg::CFG_DATA_W'($urandom_range(1, 4));
    endfunction

    function automatic logic [upg_pkg::CFG_DATA_W-1:0] pick_height();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r < 5) return upg_pkg::CFG_DATA_W'($urandom_range(4, 20));
        return upg_pkg::CFG_DATA_W'($urandom_range(1, 3));
    endfunction

    task automatic put_sample(input logic signed [upg_pkg::SAMPLE_W-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic put_reg(input upg_pkg::t_cfg_reg idx,
                           input logic [upg_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic write_regs(input logic [upg_pkg::CFG_DATA_W-1:0] fh,
                              input logic [upg_pkg::CFG_DATA_W-1:0] fw,
                              input logic [upg_pkg::CFG_DATA_W-1:0] w,
                              input logic [upg_pkg::CFG_DATA_W-1:0] h);
        put_reg(upg_pkg::REG_FACTOR_H, fh);
        put_reg(upg_pkg::REG_FACTOR_W, fw);
        put_reg(upg_pkg::REG_IN_WIDTH, w);
        put_reg(upg_pkg::REG_IN_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    // block may still hold a partial block after the last sum, so let it drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_rows(input logic [upg_pkg::CFG_DATA_W-1:0] fh,
                            input logic [upg_pkg::CFG_DATA_W-1:0] fw,
                            input logic [upg_pkg::CFG_DATA_W-1:0] w,
                            input logic [upg_pkg::CFG_DATA_W-1:0] h,
                            input int rows, input t_fill f, output int sent);
        int unsigned total;
        wait_idle();
        write_regs(fh, fw, w, h);
        total = clip(fh, FACTOR_MAX) * clip(fw, FACTOR_MAX) * clip(w, LINE_MAX) * rows;
        for (int unsigned k = 0; k < total; k++) begin
            put_sample(pick_sample(f));
        end
        sent = total;
    endtask

    initial begin
        int sent_words;
        int phase;
        int n;
        sent_words = 0;
        phase = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // one sample per plane
        write_regs(1, 1, 1, 1);
        put_sample(SAMPLE_LO);
        put_sample(SAMPLE_HI);
        put_sample(0);
        put_sample(-1);
        put_sample(1);

        wait_idle();
        write_regs(2, 2, 2, 1);
        put_sample(SAMPLE_HI);
        put_sample(SAMPLE_LO);
        put_sample(1);
        put_sample(2);
        put_sample(SAMPLE_HI);
        put_sample(SAMPLE_LO);
        put_sample(3);
        put_sample(4);

        // zero sizes act as one
        wait_idle();
        write_regs(0, 0, 0, 0);
        put_sample(12345);
        put_sample(-12345);
        sent_words = 15;

        // config changes land on block-row boundaries, so every block starts fresh
        while (phase < 10) begin
            n = 0;
            case (phase)
                2: run_rows(8, 8, 1, 1, 1, FILL_MIN, n);
                4: run_rows(15, 9, 1, 1, 1, FILL_MAX, n);
                6: run_rows(1, 1, upg_pkg::CFG_DATA_W'($urandom_range(1024, 2047)), 1, 1,
                            FILL_MIX, n);
                8: run_rows(1, 1, 1, upg_pkg::CFG_DATA_W'($urandom_range(4096, 8191)), 2,
                            FILL_MIX, n);
                default: begin
                    if (sent_words < 40) begin
                        run_rows(pick_factor(), pick_factor(), pick_width(), pick_height(),
                                 $urandom_range(1, 3), FILL_MIX, n);
                    end
                end
            endcase
            sent_words += n;
            phase++;
        end

        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        for (int k = 0; k < 5000 && pending != 0; k++) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
